@@ hdl/sec_pkg.sv @@
// shared types, constants and helpers for the scope edge trigger capture block
// no dependencies; imported by every module of the block

package sec_pkg;

  // capture memory geometry and auto timeout scaling
  localparam int BUFFER_DEPTH     = 4096;
  localparam int AUTO_WAIT_FACTOR = 2;
  localparam int ADDR_W           = $clog2(BUFFER_DEPTH);

  // fixed field widths
  localparam int OP_W       = 3;
  localparam int SAMPLE_W   = 12;
  localparam int MODE_W     = 3;
  localparam int OUT_ADDR_W = 12;
  localparam int COUNT_W    = 16;
  localparam int LEVEL_W    = 15;
  localparam int START_W    = 13;
  localparam int STOP_W     = 14;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_FRACTION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRETRIGGER_FRACTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SELECT         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MARGIN        = 3'd6;

  // register reset values
  localparam logic [15:0] RST_TRIGGER_FRACTION    = 16'd32768;
  localparam logic [15:0] RST_PRETRIGGER_FRACTION = 16'd16384;
  localparam logic [12:0] RST_RECORD_LENGTH       = 13'd1000;
  localparam logic        RST_EDGE_SELECT         = 1'b0;
  localparam logic [1:0]  RST_TRIGGER_MODE        = 2'd0;
  localparam logic [3:0]  RST_SAMPLE_BITS         = 4'd12;
  localparam logic [7:0]  RST_NOISE_MARGIN        = 8'd16;

  // trigger modes and edge codes
  localparam logic [1:0] TMODE_NORMAL = 2'd0;
  localparam logic [1:0] TMODE_SINGLE = 2'd1;
  localparam logic [1:0] TMODE_AUTO   = 2'd2;
  localparam logic       EDGE_SEL_RISE = 1'b0;

  // narrow converter handling
  localparam logic [3:0]          NARROW_BITS = 4'd8;
  localparam logic [SAMPLE_W-1:0] NARROW_MASK = 12'h0ff;

  // counter limits
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hffff;
  localparam logic [COUNT_W-1:0] AUTO_LIMIT_MAX = 16'hfffe;
  localparam logic [15:0]        FRACTION_FULL  = 16'hffff;

  // request op codes
  localparam logic [OP_W-1:0] OP_SAMPLE  = 3'd0;
  localparam logic [OP_W-1:0] OP_START   = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
  localparam logic [OP_W-1:0] OP_SENT    = 3'd4;

  // reported mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ARMING  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AWAIT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POST    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SENDING = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WAITRS  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DONE    = 3'd6;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_ARMING  = 7'b0000010,
    ST_AWAIT   = 7'b0000100,
    ST_POST    = 7'b0001000,
    ST_SENDING = 7'b0010000,
    ST_WAITRS  = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  // decoded command class
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SAMPLE,
    CMD_START,
    CMD_STOP,
    CMD_RESTART,
    CMD_SENT
  } cmd_op_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic                  store_enable;
    logic [OUT_ADDR_W-1:0] store_address;
    logic                  trigger_hit;
    logic                  capture_done;
    logic [OUT_ADDR_W-1:0] trigger_position;
  } out_item_t;

  typedef struct packed {
    logic [15:0] trigger_fraction;
    logic [15:0] pretrigger_fraction;
    logic [12:0] record_length;
    logic        edge_select;
    logic [1:0]  trigger_mode;
    logic [3:0]  sample_bits;
    logic [7:0]  noise_margin;
  } cfg_t;

  // queued command with its precomputed level tests
  typedef struct packed {
    cmd_op_t op;
    logic    arm_ok;
    logic    edge_ok;
  } cmd_t;

  function automatic logic [MODE_W-1:0] mode_code(state_t st);
    logic [MODE_W-1:0] code;
    case (st)
      ST_IDLE:    code = MODE_IDLE;
      ST_ARMING:  code = MODE_ARMING;
      ST_AWAIT:   code = MODE_AWAIT;
      ST_POST:    code = MODE_POST;
      ST_SENDING: code = MODE_SENDING;
      ST_WAITRS:  code = MODE_WAITRS;
      ST_DONE:    code = MODE_DONE;
      default:    code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/sec_front.sv @@
// front end: takes requests, decodes the op and runs the level tests
// depends on sec_pkg

module sec_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  sec_pkg::in_item_t in_data,
  input  sec_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push,
  output sec_pkg::cmd_t     entry
);
  import sec_pkg::*;

  logic [30:0]         level_wide;
  logic [LEVEL_W-1:0]  level;
  logic [SAMPLE_W-1:0] data;
  logic [15:0]         data_x;
  logic [15:0]         level_x;
  logic [15:0]         margin_x;
  logic                arm_ok;
  logic                edge_ok;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // level = (fraction << bits) >> 16
  assign level_wide = 31'(cfg.trigger_fraction) << cfg.sample_bits;
  assign level      = level_wide[30:16];

  // narrow converter: only the low byte counts
  assign data = (cfg.sample_bits <= NARROW_BITS) ? (in_data.sample & NARROW_MASK)
                                                 : in_data.sample;

  assign data_x   = 16'(data);
  assign level_x  = 16'(level);
  assign margin_x = 16'(cfg.noise_margin);

  always_comb begin
    if (cfg.edge_select == EDGE_SEL_RISE) begin
      arm_ok  = (data_x + margin_x) < level_x;
      edge_ok = data_x > level_x;
    end else begin
      arm_ok  = data_x > (level_x + margin_x);
      edge_ok = data_x < level_x;
    end
  end

  always_comb begin
    entry.arm_ok  = arm_ok;
    entry.edge_ok = edge_ok;
    case (in_data.op)
      OP_SAMPLE:  entry.op = CMD_SAMPLE;
      OP_START:   entry.op = CMD_START;
      OP_STOP:    entry.op = CMD_STOP;
      OP_RESTART: entry.op = CMD_RESTART;
      OP_SENT:    entry.op = CMD_SENT;
      default:    entry.op = CMD_NOP;
    endcase
  end

endmodule

@@ hdl/sec_queue.sv @@
// short command queue between the front end and the capture sequencer
// depends on sec_pkg

module sec_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sec_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sec_pkg::cmd_t head
);
  import sec_pkg::*;

  cmd_t                slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  assert property (@(posedge clk) disable iff (rst) count <= QCOUNT_W'(QUEUE_DEPTH))
    else $error("queue count past its depth");

endmodule

@@ hdl/sec_back.sv @@
// capture sequencer: state, write pointer, sample counter, trigger address
// and the result register; depends on sec_pkg

module sec_back (
  input  logic               clk,
  input  logic               rst,
  input  sec_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  sec_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sec_pkg::out_item_t out_data
);
  import sec_pkg::*;

  localparam int EXT_W = ADDR_W + OUT_ADDR_W;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  write_pointer, write_pointer_next;
  logic [COUNT_W-1:0] sample_count, sample_count_next;
  logic [ADDR_W-1:0]  trigger_address, trigger_address_next;

  logic [START_W-1:0] start_cnt;
  logic [STOP_W-1:0]  stop_cnt;
  logic [COUNT_W-1:0] auto_lim;

  logic [28:0]        prod_start;
  logic [28:0]        prod_stop;
  logic [31:0]        lim_full;

  logic [COUNT_W-1:0] cnt_inc;
  logic               auto_to;
  logic               capturing;
  logic               st_en, hit, done;
  logic [EXT_W-1:0]   addr_ext;
  logic [EXT_W-1:0]   taddr_ext;
  out_item_t          result;

  // derived counts, refreshed every cycle from the registers
  assign prod_start = 29'(cfg.record_length) * 29'(cfg.pretrigger_fraction);
  assign prod_stop  = 29'(cfg.record_length) * 29'(FRACTION_FULL - cfg.pretrigger_fraction);
  assign lim_full   = 32'(cfg.record_length) * 32'(AUTO_WAIT_FACTOR);

  always_ff @(posedge clk) begin
    start_cnt <= prod_start[28:16];
    stop_cnt  <= STOP_W'(prod_stop[28:16]) + STOP_W'(1);
    auto_lim  <= (lim_full > 32'(AUTO_LIMIT_MAX)) ? AUTO_LIMIT_MAX : lim_full[COUNT_W-1:0];
  end

  assign pop = head_valid && (!out_valid || out_ready);

  assign capturing = (state == ST_ARMING) || (state == ST_AWAIT) || (state == ST_POST);
  assign cnt_inc   = (sample_count == COUNT_MAX) ? sample_count : sample_count + 1'b1;
  assign auto_to   = (cfg.trigger_mode == TMODE_AUTO) && (cnt_inc > auto_lim);

  always_comb begin
    state_next           = state;
    write_pointer_next   = write_pointer;
    sample_count_next    = sample_count;
    trigger_address_next = trigger_address;
    st_en                = 1'b0;
    hit                  = 1'b0;
    done                 = 1'b0;
    case (head.op)
      CMD_SAMPLE: begin
        if (capturing) begin
          st_en              = 1'b1;
          write_pointer_next = (write_pointer == ADDR_W'(BUFFER_DEPTH - 1)) ?
                               '0 : write_pointer + 1'b1;
          sample_count_next  = cnt_inc;
          case (state)
            ST_ARMING: begin
              if (cnt_inc > COUNT_W'(start_cnt) && (head.arm_ok || auto_to)) begin
                state_next = ST_AWAIT;
              end
            end
            ST_AWAIT: begin
              if (head.edge_ok || auto_to) begin
                sample_count_next    = '0;
                state_next           = ST_POST;
                trigger_address_next = write_pointer;
                hit                  = 1'b1;
              end
            end
            default: begin
              if (cnt_inc >= COUNT_W'(stop_cnt)) begin
                state_next        = ST_SENDING;
                sample_count_next = '0;
                done              = 1'b1;
              end
            end
          endcase
        end
      end
      CMD_START: begin
        if (!capturing && state != ST_SENDING) begin
          write_pointer_next = '0;
          sample_count_next  = '0;
          state_next         = ST_ARMING;
        end
      end
      CMD_STOP: begin
        state_next = ST_IDLE;
      end
      CMD_RESTART: begin
        if (state == ST_WAITRS) begin
          sample_count_next = '0;
          state_next        = ST_ARMING;
        end
      end
      CMD_SENT: begin
        if (state != ST_IDLE) begin
          state_next = (cfg.trigger_mode == TMODE_SINGLE) ? ST_DONE : ST_WAITRS;
        end
      end
      default: begin
      end
    endcase
  end

  assign addr_ext  = st_en ? EXT_W'(write_pointer) : '0;
  assign taddr_ext = EXT_W'(trigger_address_next);

  always_comb begin
    result.mode             = mode_code(state_next);
    result.store_enable     = st_en;
    result.store_address    = addr_ext[OUT_ADDR_W-1:0];
    result.trigger_hit      = hit;
    result.capture_done     = done;
    result.trigger_position = taddr_ext[OUT_ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_pointer   <= '0;
      sample_count    <= '0;
      trigger_address <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        state           <= state_next;
        write_pointer   <= write_pointer_next;
        sample_count    <= sample_count_next;
        trigger_address <= trigger_address_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trigger_hit |-> out_data.mode == MODE_POST && out_data.store_enable)
    else $error("trigger hit outside post-trigger entry");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.capture_done |-> out_data.mode == MODE_SENDING && out_data.store_enable)
    else $error("capture done without entering sending");
  assert property (@(posedge clk) disable iff (rst)
    pop && (hit || done) |=> sample_count == '0)
    else $error("sample counter not cleared on trigger or done");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.store_enable |-> out_data.store_address == '0)
    else $error("store address set without store enable");

endmodule

@@ hdl/scope_edge_trigger_capture.sv @@
// scope edge trigger capture: an accepted request is decoded into the queue at the
// accepting edge, and the sequencer then takes it from the queue and registers its
// result into the result reg; throughput one request per cycle while results are taken; a waiting
// result stalls the input only once the 2-entry queue has filled
// configuration registers live here; derived counts settle in the cycle after a write
// rst (synchronous) clears state to idle, pointers and counters to zero, regs to defaults

module scope_edge_trigger_capture (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [sec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sec_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sec_pkg::in_item_t                  in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output sec_pkg::out_item_t                 out_data
);
  import sec_pkg::*;

  cfg_t cfg;

  // front to queue
  logic push;
  cmd_t push_entry;
  logic q_full;

  // queue to back
  logic head_valid;
  cmd_t head;
  logic pop;

  // configuration registers, masked to their field widths
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_fraction    <= RST_TRIGGER_FRACTION;
      cfg.pretrigger_fraction <= RST_PRETRIGGER_FRACTION;
      cfg.record_length       <= RST_RECORD_LENGTH;
      cfg.edge_select         <= RST_EDGE_SELECT;
      cfg.trigger_mode        <= RST_TRIGGER_MODE;
      cfg.sample_bits         <= RST_SAMPLE_BITS;
      cfg.noise_margin        <= RST_NOISE_MARGIN;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TRIGGER_FRACTION:    cfg.trigger_fraction    <= cfg_data;
        CFG_PRETRIGGER_FRACTION: cfg.pretrigger_fraction <= cfg_data;
        CFG_RECORD_LENGTH:       cfg.record_length       <= cfg_data[12:0];
        CFG_EDGE_SELECT:         cfg.edge_select         <= cfg_data[0];
        CFG_TRIGGER_MODE:        cfg.trigger_mode        <= cfg_data[1:0];
        CFG_SAMPLE_BITS:         cfg.sample_bits         <= cfg_data[3:0];
        CFG_NOISE_MARGIN:        cfg.noise_margin        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front: decode op, mask narrow samples, precompute arm and edge tests
  sec_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  // decouples request acceptance from result back-pressure
  sec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: capture state machine, addresses, counters, result register
  sec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ test/tb_top.sv @@
// self-checking bench for scope_edge_trigger_capture: drives requests and register
// writes, predicts every result in step with the block and compares each field
// depends on sec_pkg (hdl/sec_pkg.sv) and the block's top module
`timescale 1ns / 100ps

module tb_top;
  import sec_pkg::*;

  // codes the package does not name
  localparam logic [OP_W-1:0]      OP_RESV_FIRST  = 3'd5;
  localparam logic [OP_W-1:0]      OP_RESV_LAST   = 3'd7;
  localparam logic                 EDGE_SEL_FALL  = 1'b1;
  localparam logic [1:0]           TMODE_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;

  // run length guard and the window with no random idling on either side
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int CALM_FROM   = 800;
  localparam int CALM_TO     = 1_800;

  logic clk;
  logic rst = 1'b1;

  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  scope_edge_trigger_capture u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // requests waiting for the driver, results waiting for the block
  in_item_t  req_q[$];
  out_item_t result_q[$];
  out_item_t due_result;
  int        pushed      = 0;
  int        err_count   = 0;
  int        cycle_count = 0;
  wire       calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  // register mirror, kept in step with every write the bench issues
  cfg_t cfg_mirror = '{RST_TRIGGER_FRACTION, RST_PRETRIGGER_FRACTION, RST_RECORD_LENGTH,
                       RST_EDGE_SELECT, RST_TRIGGER_MODE, RST_SAMPLE_BITS, RST_NOISE_MARGIN};

  // capture state as the block should hold it
  logic [MODE_W-1:0]  cap_mode  = MODE_IDLE;
  logic [ADDR_W-1:0]  wr_ptr    = '0;
  logic [COUNT_W-1:0] smp_count = '0;
  logic [ADDR_W-1:0]  trig_addr = '0;

  // square-ish test waveform around the trigger level
  bit wave_high = 1'b0;
  int wave_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // level in converter counts: fraction of full scale 2^sample_bits
  function automatic int unsigned trigger_level();
    return (32'(cfg_mirror.trigger_fraction) << cfg_mirror.sample_bits) >> 16;
  endfunction

  // auto mode gives up waiting after twice the record, clamped so it can still fire
  function automatic logic auto_timeout();
    int unsigned lim;
    lim = 32'(cfg_mirror.record_length) * AUTO_WAIT_FACTOR;
    if (lim > 32'(AUTO_LIMIT_MAX))
      lim = 32'(AUTO_LIMIT_MAX);
    return (cfg_mirror.trigger_mode == TMODE_AUTO) && (32'(smp_count) > lim);
  endfunction

  // next capture state and the result one request produces
  function automatic out_item_t capture_step(in_item_t req);
    out_item_t   res;
    int unsigned lvl, start_cnt, stop_cnt, value;
    logic [ADDR_W-1:0] addr;
    logic        hit_ok;
    res       = '0;
    lvl       = trigger_level();
    start_cnt = (32'(cfg_mirror.record_length) * 32'(cfg_mirror.pretrigger_fraction)) >> 16;
    stop_cnt  = ((32'(cfg_mirror.record_length) *
                  32'(FRACTION_FULL - cfg_mirror.pretrigger_fraction)) >> 16) + 1;
    value     = 32'(req.sample);
    // narrow converter: upper sample bits are junk
    if (cfg_mirror.sample_bits <= NARROW_BITS)
      value = value & 32'(NARROW_MASK);

    case (req.op)
      OP_SAMPLE: begin
        // samples only count while a capture is running
        if (cap_mode == MODE_ARMING || cap_mode == MODE_AWAIT || cap_mode == MODE_POST) begin
          addr              = wr_ptr;
          res.store_enable  = 1'b1;
          res.store_address = addr;
          wr_ptr            = addr + 1'b1;
          if (smp_count != COUNT_MAX)
            smp_count = smp_count + 1'b1;

          if (cap_mode == MODE_ARMING) begin
            // arm once the pretrigger share is in and the signal sits past the margin, or on the auto timeout
            if (32'(smp_count) > start_cnt) begin
              if (cfg_mirror.edge_select == EDGE_SEL_RISE)
                hit_ok = (value + cfg_mirror.noise_margin) < lvl;
              else
                hit_ok = value > (lvl + cfg_mirror.noise_margin);
              if (hit_ok || auto_timeout())
                cap_mode = MODE_AWAIT;
            end
          end else if (cap_mode == MODE_AWAIT) begin
            // crossing of the level, or the auto timeout
            if (cfg_mirror.edge_select == EDGE_SEL_RISE)
              hit_ok = value > lvl;
            else
              hit_ok = value < lvl;
            if (hit_ok || auto_timeout()) begin
              smp_count       = '0;
              cap_mode        = MODE_POST;
              trig_addr       = addr;
              res.trigger_hit = 1'b1;
            end
          end else begin
            // post-trigger share complete
            if (32'(smp_count) >= stop_cnt) begin
              cap_mode         = MODE_SENDING;
              smp_count        = '0;
              res.capture_done = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        if (cap_mode != MODE_ARMING && cap_mode != MODE_AWAIT &&
            cap_mode != MODE_POST && cap_mode != MODE_SENDING) begin
          wr_ptr    = '0;
          smp_count = '0;
          cap_mode  = MODE_ARMING;
        end
      end
      OP_STOP: begin
        cap_mode = MODE_IDLE;
      end
      OP_RESTART: begin
        // restart keeps the write pointer running
        if (cap_mode == MODE_WAITRS) begin
          smp_count = '0;
          cap_mode  = MODE_ARMING;
        end
      end
      OP_SENT: begin
        if (cap_mode != MODE_IDLE)
          cap_mode = (cfg_mirror.trigger_mode == TMODE_SINGLE) ? MODE_DONE : MODE_WAITRS;
      end
      default: begin
        // reserved op codes leave everything alone
      end
    endcase

    res.mode             = cap_mode;
    res.trigger_position = trig_addr;
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // driver: holds valid and payload until accepted, idles at random on 9 in 100 draws outside the calm window
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        in_valid <= 1'b1;
        in_data  <= req_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls on its own random schedule
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // monitor: predict on each accepted request, check each accepted result in order
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        result_q.push_back(capture_step(in_data));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding, mode %0d", out_data.mode);
          err_count++;
        end else begin
          due_result = result_q.pop_front();
          check_field("mode", due_result.mode, out_data.mode);
          check_field("store_enable", due_result.store_enable, out_data.store_enable);
          check_field("store_address", due_result.store_address, out_data.store_address);
          check_field("trigger_hit", due_result.trigger_hit, out_data.trigger_hit);
          check_field("capture_done", due_result.capture_done, out_data.capture_done);
          check_field("trigger_position", due_result.trigger_position,
                      out_data.trigger_position);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_req(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp);
    in_item_t item;
    item.op     = op;
    item.sample = smp;
    req_q.push_back(item);
    pushed++;
  endtask

  // a sample near the level: mostly clear of the margin on one side, some exact
  // boundary values, some anywhere in range
  function automatic logic [SAMPLE_W-1:0] wave_value(bit high_side);
    int lvl, nm, full_scale, jit, v;
    lvl        = int'(trigger_level());
    nm         = int'(cfg_mirror.noise_margin);
    full_scale = (cfg_mirror.sample_bits <= NARROW_BITS) ? int'(NARROW_MASK)
                                                          : (1 << SAMPLE_W) - 1;
    jit        = $urandom_range(0, 40);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       v = lvl - nm - 1;
          1:       v = lvl - nm;
          2:       v = lvl;
          3:       v = lvl + 1;
          4:       v = lvl + nm;
          5:       v = lvl + nm + 1;
          default: v = ($urandom_range(0, 1) != 0) ? full_scale : 0;
        endcase
      end
      1:       v = $urandom_range(0, full_scale);
      default: v = high_side ? lvl + nm + 1 + jit : lvl - nm - 1 - jit;
    endcase
    if (v < 0)
      v = 0;
    if (v > full_scale)
      v = full_scale;
    // narrow converter: fill the ignored upper bits with noise
    if (cfg_mirror.sample_bits <= NARROW_BITS)
      v = v | (int'($urandom_range(0, 15)) << 8);
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic push_samples(int n, bit noisy);
    repeat (n) begin
      if (wave_left == 0) begin
        wave_high = ~wave_high;
        wave_left = $urandom_range(1, 8);
      end
      wave_left--;
      // stray requests of any code, including stops that break the run
      if (noisy && $urandom_range(0, 99) < 8)
        push_req(OP_W'($urandom_range(0, 7)), SAMPLE_W'($urandom));
      else
        push_req(OP_SAMPLE, wave_value(wave_high));
    end
  endtask

  // whole capture runs: start, bursts of samples, data sent, restart, sometimes stop
  task automatic gen_runs(int target, bit full);
    int first, rl;
    first = pushed;
    rl    = int'(cfg_mirror.record_length);
    while (pushed - first < target) begin
      push_req(OP_START, SAMPLE_W'($urandom));
      repeat (full ? 1 : $urandom_range(1, 3)) begin
        push_samples(full ? 2 * rl + 8 : $urandom_range(1, rl + rl / 2 + 6), !full);
        if ($urandom_range(0, 99) < 85)
          push_req(OP_SENT, SAMPLE_W'($urandom));
        if ($urandom_range(0, 99) < 25)
          push_samples($urandom_range(1, 3), 1'b1);
        if ($urandom_range(0, 99) < 75)
          push_req(OP_RESTART, SAMPLE_W'($urandom));
      end
      if ($urandom_range(0, 99) < 30)
        push_req(OP_STOP, SAMPLE_W'($urandom));
    end
  endtask

  // wait until the block has nothing in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // one register write; bits above the register's width carry noise
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, int width);
    logic [CFG_DATA_W-1:0] data;
    data = val | (CFG_DATA_W'($urandom) & ~CFG_DATA_W'((32'd1 << width) - 1));
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_TRIGGER_FRACTION:    cfg_mirror.trigger_fraction    = data;
      CFG_PRETRIGGER_FRACTION: cfg_mirror.pretrigger_fraction = data;
      CFG_RECORD_LENGTH:       cfg_mirror.record_length       = data[12:0];
      CFG_EDGE_SELECT:         cfg_mirror.edge_select         = data[0];
      CFG_TRIGGER_MODE:        cfg_mirror.trigger_mode        = data[1:0];
      CFG_SAMPLE_BITS:         cfg_mirror.sample_bits         = data[3:0];
      CFG_NOISE_MARGIN:        cfg_mirror.noise_margin        = data[7:0];
      default: begin
        // unused index, nothing to mirror
      end
    endcase
  endtask

  // drain, rewrite every register, let the derived counts settle
  task automatic apply_phase(logic [15:0] tf, logic [15:0] pre, logic [12:0] rl,
                             logic edge_sel, logic [1:0] tm, logic [3:0] sb, logic [7:0] nm);
    wait_drained();
    write_reg(CFG_TRIGGER_FRACTION, tf, 16);
    write_reg(CFG_PRETRIGGER_FRACTION, pre, 16);
    write_reg(CFG_RECORD_LENGTH, 16'(rl), 13);
    write_reg(CFG_EDGE_SELECT, 16'(edge_sel), 1);
    write_reg(CFG_TRIGGER_MODE, 16'(tm), 2);
    write_reg(CFG_SAMPLE_BITS, 16'(sb), 4);
    write_reg(CFG_NOISE_MARGIN, 16'(nm), 8);
    if ($urandom_range(0, 1) != 0)
      write_reg(CFG_UNUSED, CFG_DATA_W'($urandom), CFG_DATA_W);
    @(posedge clk);
    cfg_write <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // at reset settings: everything outside a capture is ignored
    push_req(OP_SAMPLE, 12'hfff);
    push_req(OP_RESV_FIRST, 12'h000);
    push_req(OP_RESV_LAST, 12'hfff);
    push_req(OP_SENT, 12'h000);
    push_req(OP_RESTART, 12'hfff);

    // level 2048, margin 16, arm after 2 samples, done 6 samples past the trigger
    apply_phase(16'd32768, 16'd16384, 13'd8, EDGE_SEL_RISE, TMODE_NORMAL, 4'd12, 8'd16);
    push_req(OP_START, 12'h000);
    push_req(OP_START, 12'hfff);          // already arming, ignored
    push_req(OP_SAMPLE, 12'd0);           // inside the pretrigger share
    push_req(OP_SAMPLE, 12'd0);
    push_req(OP_SAMPLE, 12'd2032);        // exactly on the margin, does not arm
    push_req(OP_SAMPLE, 12'd2031);        // arms
    push_req(OP_SAMPLE, 12'd2048);        // at the level, no crossing
    push_req(OP_SAMPLE, 12'd2049);        // trigger
    repeat (6) push_req(OP_SAMPLE, 12'hfff);
    push_req(OP_START, 12'h000);          // sending, ignored
    push_req(OP_SAMPLE, 12'd100);         // not stored while sending
    push_req(OP_RESTART, 12'h000);        // only valid from wait restart
    push_req(OP_SENT, 12'h000);
    push_req(OP_RESTART, 12'h000);
    push_req(OP_STOP, 12'h000);
    push_req(OP_SENT, 12'h000);           // idle, ignored

    // sender pauses here until the block has delivered everything
    wait_drained();

    // extremes of the fraction and noise margin registers
    apply_phase(16'd0, 16'd0, 13'd1, EDGE_SEL_RISE, TMODE_NORMAL, 4'd12, 8'd0);
    gen_runs(40, 1'b0);
    apply_phase(16'hffff, 16'hffff, 13'd5, EDGE_SEL_FALL, TMODE_SINGLE, 4'd12, 8'd255);
    gen_runs(40, 1'b0);
    // zero-length record
    apply_phase(16'd30000, 16'd16384, 13'd0, EDGE_SEL_FALL, TMODE_AUTO, 4'd8, 8'd3);
    gen_runs(40, 1'b0);
    // level above every sample: only the auto timeout gets through
    apply_phase(16'd40000, 16'd30000, 13'd20, EDGE_SEL_RISE, TMODE_AUTO, 4'd15, 8'd7);
    gen_runs(60, 1'b0);
    // reserved trigger mode behaves as normal; zero resolution puts the level at 0
    apply_phase(16'd20000, 16'd50000, 13'd12, EDGE_SEL_FALL, TMODE_RESERVED, 4'd0, 8'd1);
    gen_runs(40, 1'b0);
    apply_phase(16'd52000, 16'd8000, 13'd30, EDGE_SEL_RISE, TMODE_SINGLE, 4'd9, 8'd255);
    gen_runs(40, 1'b0);
    // narrow converter
    apply_phase(16'd24000, 16'd40000, 13'd16, EDGE_SEL_FALL, TMODE_NORMAL, 4'd8, 8'd0);
    gen_runs(50, 1'b0);

    // random settings, small records
    while (pushed < 1300) begin
      apply_phase(16'($urandom), 16'($urandom),
                  ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 48)),
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(8, 12)),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 40)));
      gen_runs($urandom_range(30, 80), 1'b0);
    end

    // widest record lengths: the derived counts use every product bit
    apply_phase(16'd30000, 16'd0, 13'd8191, EDGE_SEL_RISE, TMODE_AUTO, 4'd12, 8'd16);
    push_req(OP_START, 12'h000);
    repeat (12) push_req(OP_SAMPLE, SAMPLE_W'($urandom));
    push_req(OP_STOP, 12'h000);
    apply_phase(16'd25000, 16'hffff, 13'd4096, EDGE_SEL_FALL, TMODE_NORMAL, 4'd12, 8'd0);
    push_req(OP_START, 12'h000);
    repeat (12) push_req(OP_SAMPLE, SAMPLE_W'($urandom));
    push_req(OP_SENT, 12'h000);
    push_req(OP_STOP, 12'h000);

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
